FILE: rtl/core/aar_pkg.sv
// Package for the area-averaging resampler: payload structs, field widths,
// register addresses and datapath widths shared by the RTL.
// Depends on nothing.
package aar_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned STEP_W      = 24;
  localparam int unsigned INV_W       = 22;
  localparam int unsigned SUM_W       = 42;
  localparam int unsigned SUM_LO_W    = SUM_W / 2;
  localparam int unsigned TB_W        = 25;
  localparam int unsigned MUL_A_W     = 25;
  localparam int unsigned MUL_B_W     = INV_W;
  localparam int unsigned MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned PACC_W      = 64;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;

  localparam logic REG_STEP = 1'b0;
  localparam logic REG_INV  = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
  localparam logic [INV_W-1:0]  INV_RESET  = INV_W'(65536);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          final_res;
  } out_item_t;

endpackage

FILE: rtl/core/area_average_resampler.sv
// Top level of the area-averaging (box filter) sample-rate converter.
// Uses aar_pkg for the payload structs, register addresses and widths.
// Holds the sequencer, the shared multiplier and the APB register file.

// Each input transaction spans one input period and is split at output window
// boundaries; every piece is weighted by its overlap and accumulated. A closed
// window is scaled by inv_step, floored and saturated; a window that lies inside
// one input gives that sample unscaled. All products go through one shared
// 25x22 multiplier, so in_stall_o stays high while an input is at work: through
// a multiply and an accumulate step for each window piece, the scaling steps for
// each scaled output, the emit step for each output, and any wait on out_stall_i.
// The input marked last flushes the open partial window and marks the final
// output with final_res.
module area_average_resampler #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  aar_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output aar_pkg::out_item_t         out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aar_pkg::ADDR_W-1:0] paddr,
  input  logic [aar_pkg::DATA_W-1:0] pwdata,
  output logic [aar_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned SB = aar_pkg::SAMPLE_BITS;
  localparam int unsigned TW = aar_pkg::TB_W;
  localparam int unsigned PW = aar_pkg::PACC_W;
  localparam int unsigned LW = aar_pkg::SUM_LO_W;
  localparam int unsigned SW = aar_pkg::SUM_W;

  localparam logic [FRAC_BITS:0] ONE_PERIOD = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [TW-1:0]      STEP_MIN   = TW'((2 ** FRAC_BITS) / 63 + 1);
  localparam logic [PW-1:0]      FRAC_MASK  = (PW'(1) << (2 * FRAC_BITS)) - PW'(1);
  localparam logic [PW-1:0]      POS_LIM    = PW'(2 ** (SB - 1) - 1);
  localparam logic [PW-1:0]      NEG_LIM    = POS_LIM + PW'(1);
  localparam logic [SB-1:0]      SAT_MAX    = SB'(2 ** (SB - 1) - 1);
  localparam logic [SB-1:0]      SAT_MIN    = SAT_MAX + SB'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_ABS,
    S_SL,
    S_SH,
    S_SUM,
    S_RND,
    S_EMIT
  } state_e;

  state_e                         state_q, state_d;
  logic signed [SB-1:0]           sample_q, sample_d;
  logic                           last_q, last_d;
  logic [FRAC_BITS:0]             rem_q, rem_d;
  logic [TW-1:0]                  tb_q, tb_d;
  logic                           open_q, open_d;
  logic                           opened_q, opened_d;
  logic                           close_q, close_d;
  logic signed [SW-1:0]           sum_q, sum_d;
  logic [aar_pkg::MUL_P_W-1:0]    prod_q, prod_d;
  logic [SW-1:0]                  mag_q, mag_d;
  logic                           neg_q, neg_d;
  logic [PW-1:0]                  pacc_q, pacc_d;
  logic [SB-1:0]                  res_q, res_d;
  logic                           res_final_q, res_final_d;
  logic                           out_valid_q, out_valid_d;
  aar_pkg::out_item_t             out_data_q, out_data_d;
  logic [aar_pkg::STEP_W-1:0]     step_q, step_d;
  logic [aar_pkg::INV_W-1:0]      inv_q, inv_d;

  logic [TW-1:0]                  eff_step, tb_eff, rem_ext, weight;
  logic [SB-1:0]                  s_mag;
  logic [aar_pkg::MUL_A_W-1:0]    mul_a;
  logic [aar_pkg::MUL_B_W-1:0]    mul_b;
  logic [aar_pkg::MUL_P_W-1:0]    mul_p;
  logic signed [SW-1:0]           prod_s, sum_new;
  logic [PW-1:0]                  quot, rnd_mag;
  logic                           frac_nz, cfg_wr;

  assign eff_step = (TW'(step_q) < STEP_MIN) ? STEP_MIN : TW'(step_q);
  assign tb_eff   = open_q ? tb_q : eff_step;
  assign rem_ext  = TW'(rem_q);
  assign weight   = (tb_eff <= rem_ext) ? tb_eff : rem_ext;
  assign s_mag    = sample_q[SB-1] ? SB'(-sample_q) : SB'(sample_q);

  always_comb begin
    case (state_q)
      S_MUL: begin
        mul_a = weight;
        mul_b = aar_pkg::MUL_B_W'(s_mag);
      end
      S_SL: begin
        mul_a = aar_pkg::MUL_A_W'(mag_q[LW-1:0]);
        mul_b = inv_q;
      end
      S_SH: begin
        mul_a = aar_pkg::MUL_A_W'(mag_q[SW-1:LW]);
        mul_b = inv_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = aar_pkg::MUL_P_W'(mul_a) * aar_pkg::MUL_P_W'(mul_b);
  assign prod_s  = $signed(prod_q[SW-1:0]);
  assign sum_new = sample_q[SB-1] ? (sum_q - prod_s) : (sum_q + prod_s);
  assign quot    = pacc_q >> (2 * FRAC_BITS);
  assign frac_nz = |(pacc_q & FRAC_MASK);
  assign rnd_mag = quot + PW'(neg_q && frac_nz);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    state_d     = state_q;
    sample_d    = sample_q;
    last_d      = last_q;
    rem_d       = rem_q;
    tb_d        = tb_q;
    open_d      = open_q;
    opened_d    = opened_q;
    close_d     = close_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    pacc_d      = pacc_q;
    res_d       = res_q;
    res_final_d = res_final_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    step_d      = step_q;
    inv_d       = inv_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_wr) begin
      case (paddr[2])
        aar_pkg::REG_STEP: step_d = pwdata[aar_pkg::STEP_W-1:0];
        aar_pkg::REG_INV:  inv_d  = pwdata[aar_pkg::INV_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sample_d = in_data_i.sample;
          last_d   = in_data_i.last;
          rem_d    = ONE_PERIOD;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        opened_d = !open_q;
        open_d   = 1'b1;
        prod_d   = mul_p;
        if (tb_eff <= rem_ext) begin
          close_d = 1'b1;
          rem_d   = rem_q - tb_eff[FRAC_BITS:0];
        end else begin
          close_d = 1'b0;
          tb_d    = tb_eff - rem_ext;
          rem_d   = '0;
        end
        state_d = S_ACC;
      end
      S_ACC: begin
        if (close_q) begin
          open_d      = 1'b0;
          res_final_d = last_q && (rem_q == '0);
          if (opened_q) begin
            res_d   = sample_q;
            sum_d   = '0;
            state_d = S_EMIT;
          end else begin
            sum_d   = sum_new;
            state_d = S_ABS;
          end
        end else begin
          sum_d = sum_new;
          if (last_q) begin
            res_final_d = 1'b1;
            state_d     = S_ABS;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_ABS: begin
        neg_d   = sum_q[SW-1];
        mag_d   = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
        sum_d   = '0;
        open_d  = 1'b0;
        state_d = S_SL;
      end
      S_SL: begin
        prod_d  = mul_p;
        state_d = S_SH;
      end
      S_SH: begin
        pacc_d  = PW'(prod_q);
        prod_d  = mul_p;
        state_d = S_SUM;
      end
      S_SUM: begin
        pacc_d  = pacc_q + (PW'(prod_q) << LW);
        state_d = S_RND;
      end
      S_RND: begin
        if (neg_q) begin
          res_d = (rnd_mag > NEG_LIM) ? SAT_MIN : SB'(-rnd_mag);
        end else begin
          res_d = (rnd_mag > POS_LIM) ? SAT_MAX : rnd_mag[SB-1:0];
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_data_d.value     = res_q;
          out_data_d.final_res = res_final_q;
          state_d              = (rem_q != '0) ? S_MUL : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sample_q    <= '0;
      last_q      <= 1'b0;
      rem_q       <= '0;
      tb_q        <= '0;
      open_q      <= 1'b0;
      opened_q    <= 1'b0;
      close_q     <= 1'b0;
      sum_q       <= '0;
      prod_q      <= '0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      pacc_q      <= '0;
      res_q       <= '0;
      res_final_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      step_q      <= aar_pkg::STEP_RESET;
      inv_q       <= aar_pkg::INV_RESET;
    end else begin
      state_q     <= state_d;
      sample_q    <= sample_d;
      last_q      <= last_d;
      rem_q       <= rem_d;
      tb_q        <= tb_d;
      open_q      <= open_d;
      opened_q    <= opened_d;
      close_q     <= close_d;
      sum_q       <= sum_d;
      prod_q      <= prod_d;
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      pacc_q      <= pacc_d;
      res_q       <= res_d;
      res_final_q <= res_final_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      step_q      <= step_d;
      inv_q       <= inv_d;
    end
  end

  always_comb begin
    case (paddr[2])
      aar_pkg::REG_STEP: prdata = aar_pkg::DATA_W'(step_q);
      aar_pkg::REG_INV:  prdata = aar_pkg::DATA_W'(inv_q);
      default:           prdata = '0;
    endcase
  end

  assign pready      = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_idle_no_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (rem_q == '0))
    else $error("input period left over while idle");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_MUL))
    else $error("accepted transaction did not start the sequencer");

  a_open_tb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_q && !close_q) |-> (tb_q != '0))
    else $error("open window with no distance to its boundary");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for area_average_resampler: directed and random sample streams
// over many step settings, checked against a resampling predictor kept here or plan rows.
// Depends on aar_pkg and the area_average_resampler top level only.
module tb;

  localparam int unsigned FRAC_BITS     = 16;
  localparam longint      ONE_PERIOD    = longint'(1) << FRAC_BITS;
  localparam longint      STEP_FLOOR    = ONE_PERIOD / 63 + 1;
  localparam longint      SAT_HI        = (longint'(1) << (aar_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint      SAT_LO        = -SAT_HI - 1;
  localparam longint      INV_MAX       = (longint'(1) << aar_pkg::INV_W) - 1;
  localparam int unsigned MAX_PER_ITEM  = 64;
  localparam int unsigned N_RANDOM      = 400;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned HOLD_AFTER    = 180;
  localparam int unsigned DRAIN_LIMIT   = 200000;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_STEP, ROW_INV} row_kind_e;

  typedef struct {
    row_kind_e kind;
    int        word;
    bit        lst;
    bit        typed;
    int        exp_value;
    bit        exp_final;
  } plan_row_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  aar_pkg::in_item_t          in_data_i   = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  aar_pkg::out_item_t         out_data_o;
  logic                       psel        = 1'b0;
  logic                       penable     = 1'b0;
  logic                       pwrite      = 1'b0;
  logic [aar_pkg::ADDR_W-1:0] paddr       = '0;
  logic [aar_pkg::DATA_W-1:0] pwdata      = '0;
  logic [aar_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  logic                       row_typed   = 1'b0;
  aar_pkg::out_item_t         row_expect  = '0;

  logic [aar_pkg::STEP_W-1:0] cur_step    = aar_pkg::STEP_RESET;
  logic [aar_pkg::INV_W-1:0]  cur_inv     = aar_pkg::INV_RESET;
  longint                     win_sum     = 0;
  longint                     win_left    = longint'(aar_pkg::STEP_RESET);
  bit                         win_live    = 1'b0;

  aar_pkg::out_item_t         expected_samples[$];
  int unsigned                n_in_seen   = 0;
  int unsigned                n_out_seen  = 0;
  int unsigned                n_writes    = 0;
  int unsigned                n_errors    = 0;

  area_average_resampler #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #2 clk_i = ~clk_i;

  function automatic longint live_step();
    return (cur_step < STEP_FLOOR) ? STEP_FLOOR : longint'(cur_step);
  endfunction

  function automatic logic signed [aar_pkg::SAMPLE_BITS-1:0] window_average(longint total);
    logic signed [95:0] prod;
    prod = total;
    prod = prod * $signed({1'b0, cur_inv});
    prod = prod >>> (2 * FRAC_BITS);
    if (prod > SAT_HI) prod = SAT_HI;
    if (prod < SAT_LO) prod = SAT_LO;
    return prod[aar_pkg::SAMPLE_BITS-1:0];
  endfunction

  function automatic void resample_item(input aar_pkg::in_item_t it,
                                        ref aar_pkg::out_item_t res[$]);
    longint             smp;
    longint             left;
    bit                 fresh;
    aar_pkg::out_item_t r;
    smp  = longint'(it.sample);
    left = ONE_PERIOD;
    res  = {};
    while (left > 0 && res.size() < MAX_PER_ITEM) begin
      fresh = 1'b0;
      if (!win_live) begin
        win_left = live_step();
        win_live = 1'b1;
        fresh    = 1'b1;
      end
      if (win_left <= left) begin
        win_sum += smp * win_left;
        left    -= win_left;
        r.value     = fresh ? it.sample : window_average(win_sum);
        r.final_res = 1'b0;
        res.push_back(r);
        win_sum  = 0;
        win_live = 1'b0;
      end else begin
        win_sum  += smp * left;
        win_left -= left;
        left      = 0;
      end
    end
    if (it.last) begin
      if (win_live && res.size() < MAX_PER_ITEM) begin
        r.value     = window_average(win_sum);
        r.final_res = 1'b0;
        res.push_back(r);
      end
      if (res.size() > 0) begin
        r = res.pop_back();
        r.final_res = 1'b1;
        res.push_back(r);
      end
      win_sum  = 0;
      win_live = 1'b0;
      win_left = live_step();
    end
  endfunction

  always @(posedge clk_i) begin : watch
    aar_pkg::out_item_t fresh_q[$];
    aar_pkg::out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        resample_item(in_data_i, fresh_q);
        n_in_seen++;
        if (row_typed) begin
          expected_samples.push_back(row_expect);
        end else begin
          foreach (fresh_q[k]) expected_samples.push_back(fresh_q[k]);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        n_out_seen++;
        if (expected_samples.size() == 0) begin
          $error("unexpected output transaction: value %0d final_res %0d",
                 out_data_o.value, out_data_o.final_res);
          n_errors++;
        end else begin
          want = expected_samples.pop_front();
          if (out_data_o.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_data_o.value);
            n_errors++;
          end
          if (out_data_o.final_res !== want.final_res) begin
            $error("final_res: expected %0d, got %0d", want.final_res, out_data_o.final_res);
            n_errors++;
          end
        end
      end
    end
  end

  task automatic send_sample(input aar_pkg::in_item_t it, input bit typed,
                             input aar_pkg::out_item_t want);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  <= it;
    row_typed  <= typed;
    row_expect <= want;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_reg(input logic idx, input logic [aar_pkg::DATA_W-1:0] val);
    logic [aar_pkg::DATA_W-1:0] mask;
    mask = (idx == aar_pkg::REG_STEP) ?
           aar_pkg::DATA_W'((64'd1 << aar_pkg::STEP_W) - 1) :
           aar_pkg::DATA_W'((64'd1 << aar_pkg::INV_W) - 1);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (idx == aar_pkg::REG_STEP) cur_step = val[aar_pkg::STEP_W-1:0];
    else cur_inv = val[aar_pkg::INV_W-1:0];
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if ((prdata & mask) !== (val & mask)) begin
      $error("register %0d readback: expected %0d, got %0d", idx, val & mask, prdata & mask);
      n_errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    n_writes++;
  endtask

  initial begin : rx_side
    int unsigned r;
    int unsigned len;
    bit          held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (!held && n_in_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        len = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall_i <= 1'b0;
          len = $urandom_range(1, 8);
        end else if (r < 88) begin
          out_stall_i <= 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 96) begin
          out_stall_i <= 1'b0;
          len = $urandom_range(30, 80);
        end else begin
          out_stall_i <= 1'b1;
          len = $urandom_range(10, 40);
        end
      end
      repeat (len) @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #25_000_000;
    $error("simulation timed out with %0d samples outstanding", expected_samples.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    plan_row_t                  plan[$];
    aar_pkg::in_item_t          it;
    aar_pkg::out_item_t         want;
    logic [aar_pkg::DATA_W-1:0] step_val;
    logic [aar_pkg::DATA_W-1:0] inv_val;
    longint                     eff;
    longint                     inv_calc;
    int unsigned                r;
    int unsigned                len;
    int unsigned                n_streams;
    int unsigned                n_rand;
    int unsigned                waited;
    bit                         open_tail;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    plan.push_back('{ROW_SAMPLE, 32767, 1'b0, 1'b1, 32767, 1'b0});
    plan.push_back('{ROW_SAMPLE, -32768, 1'b0, 1'b1, -32768, 1'b0});
    plan.push_back('{ROW_SAMPLE, 0, 1'b0, 1'b1, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, -1, 1'b0, 1'b1, -1, 1'b0});
    plan.push_back('{ROW_SAMPLE, 1, 1'b1, 1'b1, 1, 1'b1});
    plan.push_back('{ROW_STEP, 131072, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_INV, 32768, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, 32767, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, 32767, 1'b0, 1'b1, 32767, 1'b0});
    plan.push_back('{ROW_SAMPLE, -32768, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, -32768, 1'b0, 1'b1, -32768, 1'b0});
    plan.push_back('{ROW_SAMPLE, 12345, 1'b1, 1'b1, 6172, 1'b1});
    plan.push_back('{ROW_STEP, 32768, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_INV, 131072, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, -32768, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, 100, 1'b1, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_STEP, 0, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_INV, 3904000, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, 32767, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, -5, 1'b1, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_STEP, 98304, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_INV, 0, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, 1000, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, 2000, 1'b0, 1'b1, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, 3000, 1'b1, 1'b1, 0, 1'b1});
    plan.push_back('{ROW_STEP, 16777215, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_INV, 256, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, 32767, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, -32768, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, 7, 1'b1, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_STEP, 131072, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_INV, 3904000, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, 32767, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, 32767, 1'b0, 1'b1, 32767, 1'b0});
    plan.push_back('{ROW_SAMPLE, -32768, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, -32768, 1'b0, 1'b1, -32768, 1'b0});
    plan.push_back('{ROW_SAMPLE, 500, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_STEP, 1100, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, 600, 1'b0, 1'b0, 0, 1'b0});
    plan.push_back('{ROW_SAMPLE, -600, 1'b1, 1'b0, 0, 1'b0});

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_STEP: program_reg(aar_pkg::REG_STEP, plan[i].word);
        ROW_INV:  program_reg(aar_pkg::REG_INV, plan[i].word);
        default: begin
          it.sample       = plan[i].word[aar_pkg::SAMPLE_BITS-1:0];
          it.last         = plan[i].lst;
          want.value      = plan[i].exp_value[aar_pkg::SAMPLE_BITS-1:0];
          want.final_res  = plan[i].exp_final;
          send_sample(it, plan[i].typed, want);
        end
      endcase
    end

    n_rand = 0;
    while (n_rand < N_RANDOM) begin
      r = $urandom_range(0, 99);
      if (r < 10) step_val = $urandom_range(0, int'(STEP_FLOOR - 1));
      else if (r < 20) begin
        case ($urandom_range(0, 2))
          0:       step_val = 1100;
          1:       step_val = 16777215;
          default: step_val = 65536;
        endcase
      end else if (r < 30) step_val = $urandom_range(0, (1 << aar_pkg::STEP_W) - 1);
      else step_val = $urandom_range(1100, 4 * 65536);
      eff = (step_val < STEP_FLOOR) ? STEP_FLOOR : longint'(step_val);
      inv_calc = (longint'(1) << (2 * FRAC_BITS)) / eff;
      if (inv_calc > INV_MAX) inv_calc = INV_MAX;
      r = $urandom_range(0, 99);
      if (r < 70) inv_val = inv_calc[aar_pkg::DATA_W-1:0];
      else if (r < 80) inv_val = 0;
      else if (r < 90) inv_val = $urandom_range(0, int'(INV_MAX));
      else begin
        case ($urandom_range(0, 2))
          0:       inv_val = 256;
          1:       inv_val = 3904000;
          default: inv_val = INV_MAX[aar_pkg::DATA_W-1:0];
        endcase
      end
      program_reg(aar_pkg::REG_STEP, step_val);
      program_reg(aar_pkg::REG_INV, inv_val);

      n_streams = $urandom_range(1, 4);
      open_tail = ($urandom_range(0, 99) < 15);
      for (int unsigned s = 0; s < n_streams; s++) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
        for (int unsigned k = 0; k < len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 15) begin
            case ($urandom_range(0, 3))
              0:       it.sample = 16'sh7fff;
              1:       it.sample = 16'sh8000;
              2:       it.sample = 16'sh0000;
              default: it.sample = 16'shffff;
            endcase
          end else if (r < 30) begin
            it.sample = aar_pkg::SAMPLE_BITS'($signed($urandom_range(0, 400)) - 200);
          end else begin
            it.sample = aar_pkg::SAMPLE_BITS'($urandom_range(0, 16'hffff));
          end
          it.last = (k == len - 1) && !(open_tail && s == n_streams - 1);
          send_sample(it, 1'b0, '0);
          n_rand++;
        end
      end
    end

    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_samples.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (expected_samples.size() != 0) begin
      $error("%0d expected samples never arrived", expected_samples.size());
      n_errors++;
    end
    $display("Checked %0d input and %0d output transactions over %0d register writes,",
             n_in_seen, n_out_seen, n_writes);
    $display("including step floor, zero inv_step, saturation and mid-stream step changes.");
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
